>>> rtl/core/kter_pkg.sv
// Shared types, constants and binary64 helpers for the Kruskal element reconstruct block.
package kter_pkg;

   localparam int unsigned MAX_MODES_DEF = 4;
   localparam int unsigned MAX_ROWS_DEF  = 64;
   localparam int unsigned MAX_RANK_DEF  = 16;
   localparam int unsigned QUERY_MODES   = 4;
   localparam int unsigned CSR_IDX_W     = 3;
   localparam int unsigned CSR_DATA_W    = 7;

   localparam logic [63:0] FP_ONE  = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] FP_ZERO = 64'h0;

   typedef enum logic [1:0] {
      OP_LOAD_FACTOR = 2'd0,
      OP_LOAD_WEIGHT = 2'd1,
      OP_QUERY       = 2'd2,
      OP_NONE        = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_MODE_COUNT = 3'd0,
      CSR_ROWS_MODE0 = 3'd1,
      CSR_ROWS_MODE1 = 3'd2,
      CSR_ROWS_MODE2 = 3'd3,
      CSR_ROWS_MODE3 = 3'd4,
      CSR_RANK       = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [1:0]  mode_select;
      logic [5:0]  row_index;
      logic [3:0]  component_index;
      logic [63:0] load_value;
      logic [5:0]  query_index_0;
      logic [5:0]  query_index_1;
      logic [5:0]  query_index_2;
      logic [5:0]  query_index_3;
   } req_word_type;

   typedef struct packed {
      logic [63:0] element_value;
      logic        index_error;
   } rsp_word_type;

   typedef struct packed {
      logic start;
      logic is_add;
   } fpu_ctl_type;

   typedef enum logic [1:0] {
      SP_NORM = 2'd0,
      SP_ZERO = 2'd1,
      SP_INF  = 2'd2,
      SP_NAN  = 2'd3
   } fp_class_type;

endpackage

>>> rtl/core/kter_ram.sv
// Generic single-port write, single-port registered-read RAM.
module kter_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/core/kter_fpu.sv
// Shared multi-cycle binary64 multiply/add unit, round to nearest even.
module kter_fpu (
   input  logic                 clock,
   input  logic                 reset,
   input  kter_pkg::fpu_ctl_type ctl,
   input  logic [63:0]          op_a,
   input  logic [63:0]          op_b,
   output logic                 done,
   output logic [63:0]          result
);
   import kter_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_MULN,
      S_ALIGN, S_ADDSUM, S_NORM, S_ROUND, S_DONE
   } state_type;

   state_type    state_ff;
   logic         done_ff;
   logic [63:0]  result_ff;
   logic         sa_ff, sb_ff;
   logic [12:0]  ea_ff, eb_ff;
   logic [52:0]  ma_ff, mb_ff;
   logic [1:0]   ca_ff, cb_ff;
   logic [107:0] prod_ff;
   logic         rs_ff;
   logic signed [13:0] re_ff;
   logic [107:0] rm_ff;

   function automatic fp_class_type fp_class(input logic [63:0] v);
      if (v[62:52] == 11'h7FF) begin
         fp_class = (v[51:0] != 0) ? SP_NAN : SP_INF;
      end else if (v[62:0] == 63'h0) begin
         fp_class = SP_ZERO;
      end else begin
         fp_class = SP_NORM;
      end
   endfunction

   function automatic logic [52:0] fp_mant(input logic [63:0] v);
      fp_mant = {(v[62:52] != 0), v[51:0]};
   endfunction

   function automatic logic [12:0] fp_exp(input logic [63:0] v);
      fp_exp = (v[62:52] == 0) ? 13'd1 : {2'b00, v[62:52]};
   endfunction

   // 27x27 partial products; mantissa split into a 27-bit low half and a 26-bit high half
   logic [26:0] a_part, b_part;
   logic [53:0] pp;
   always_comb begin
      a_part = (state_ff == S_MUL0 || state_ff == S_MUL2) ? ma_ff[26:0]
                                                          : {1'b0, ma_ff[52:27]};
      b_part = (state_ff == S_MUL0 || state_ff == S_MUL1) ? mb_ff[26:0]
                                                          : {1'b0, mb_ff[52:27]};
      pp = a_part * b_part;
   end

   // align datapath
   logic [12:0]  ediff;
   logic [107:0] big_m, small_m, small_sh;
   logic         sticky_sh;
   always_comb begin
      ediff = ea_ff - eb_ff;
      big_m = {1'b0, ma_ff, 54'h0};
      small_m = {1'b0, mb_ff, 54'h0};
      small_sh = (ediff > 13'd107) ? 108'h0 : (small_m >> ediff);
      sticky_sh = (ediff > 13'd107) ? (small_m != 0)
                : ((small_m & ~({108{1'b1}} << ediff)) != 0);
   end

   // rounding of rm_ff: value = rm_ff[107:0] with hidden at bit 106, exponent re_ff
   logic [52:0]  r_mant;
   logic         r_g, r_st, r_inc;
   logic [53:0]  r_sum;
   logic signed [13:0] r_exp;
   logic [63:0]  r_bits;
   always_comb begin
      r_mant = rm_ff[106:54];
      r_g    = rm_ff[53];
      r_st   = (rm_ff[52:0] != 0);
      r_inc  = r_g & (r_st | r_mant[0]);
      r_sum  = {1'b0, r_mant} + {53'h0, r_inc};
      r_exp  = re_ff;
      if (r_sum[53]) begin
         r_sum = r_sum >> 1;
         r_exp = r_exp + 14'sd1;
      end
      if (r_sum[52:0] == 0) begin
         r_bits = {rs_ff, 63'h0};
      end else if (r_exp >= 14'sd2047) begin
         r_bits = {rs_ff, 11'h7FF, 52'h0};
      end else if (!r_sum[52]) begin
         r_bits = {rs_ff, 11'h0, r_sum[51:0]};
      end else begin
         r_bits = {rs_ff, r_exp[10:0], r_sum[51:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (ctl.start) begin
                  ca_ff <= fp_class(op_a);
                  cb_ff <= fp_class(op_b);
                  sa_ff <= op_a[63];
                  sb_ff <= op_b[63];
                  ma_ff <= fp_mant(op_a);
                  mb_ff <= fp_mant(op_b);
                  ea_ff <= fp_exp(op_a);
                  eb_ff <= fp_exp(op_b);
                  prod_ff <= '0;
                  state_ff <= ctl.is_add ? S_ALIGN : S_MUL0;
               end
            end
            S_MUL0: begin
               if (ca_ff == SP_NAN || cb_ff == SP_NAN ||
                   (ca_ff == SP_INF && cb_ff == SP_ZERO) ||
                   (ca_ff == SP_ZERO && cb_ff == SP_INF)) begin
                  result_ff <= 64'h7FF8_0000_0000_0000;
                  state_ff  <= S_DONE;
               end else if (ca_ff == SP_INF || cb_ff == SP_INF) begin
                  result_ff <= {sa_ff ^ sb_ff, 11'h7FF, 52'h0};
                  state_ff  <= S_DONE;
               end else if (ca_ff == SP_ZERO || cb_ff == SP_ZERO) begin
                  result_ff <= {sa_ff ^ sb_ff, 63'h0};
                  state_ff  <= S_DONE;
               end else begin
                  prod_ff  <= {54'h0, pp};
                  state_ff <= S_MUL1;
               end
            end
            S_MUL1: begin
               prod_ff  <= prod_ff + ({54'h0, pp} << 27);
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               prod_ff  <= prod_ff + ({54'h0, pp} << 27);
               state_ff <= S_MUL3;
            end
            S_MUL3: begin
               prod_ff  <= prod_ff + ({54'h0, pp} << 54);
               state_ff <= S_MULN;
            end
            S_MULN: begin
               // product hidden bit at 104 or 105; shift to 106 or 107
               rs_ff    <= sa_ff ^ sb_ff;
               rm_ff    <= prod_ff << 2;
               re_ff    <= $signed({1'b0, ea_ff}) + $signed({1'b0, eb_ff}) - 14'sd1023;
               state_ff <= S_NORM;
            end
            S_ALIGN: begin
               if (ca_ff == SP_NAN || cb_ff == SP_NAN ||
                   (ca_ff == SP_INF && cb_ff == SP_INF && sa_ff != sb_ff)) begin
                  result_ff <= 64'h7FF8_0000_0000_0000;
                  state_ff  <= S_DONE;
               end else if (ca_ff == SP_INF) begin
                  result_ff <= {sa_ff, 11'h7FF, 52'h0};
                  state_ff  <= S_DONE;
               end else if (cb_ff == SP_INF) begin
                  result_ff <= {sb_ff, 11'h7FF, 52'h0};
                  state_ff  <= S_DONE;
               end else if (ca_ff == SP_ZERO && cb_ff == SP_ZERO) begin
                  result_ff <= {sa_ff & sb_ff, 63'h0};
                  state_ff  <= S_DONE;
               end else if ({ea_ff, ma_ff} < {eb_ff, mb_ff}) begin
                  // swap so a holds the larger magnitude
                  ea_ff <= eb_ff; eb_ff <= ea_ff;
                  ma_ff <= mb_ff; mb_ff <= ma_ff;
                  sa_ff <= sb_ff; sb_ff <= sa_ff;
                  ca_ff <= cb_ff; cb_ff <= ca_ff;
               end else begin
                  prod_ff  <= small_sh | {107'h0, sticky_sh};
                  state_ff <= S_ADDSUM;
               end
            end
            S_ADDSUM: begin
               rs_ff <= sa_ff;
               // hidden of larger at bit 105 after shift by one for carry room
               if (sa_ff == sb_ff) begin
                  rm_ff <= ({1'b0, big_m[107:1]} + {1'b0, prod_ff[107:1]})
                           | {107'h0, prod_ff[0]};
               end else begin
                  rm_ff <= ({1'b0, big_m[107:1]} - {1'b0, prod_ff[107:1]})
                           - {107'h0, (prod_ff[0] & ~big_m[0])};
               end
               re_ff    <= $signed({1'b0, ea_ff}) + 14'sd1;
               state_ff <= S_NORM;
            end
            S_NORM: begin
               if (rm_ff == 0) begin
                  result_ff <= FP_ZERO;
                  state_ff  <= S_DONE;
               end else if (re_ff < -14'sd108) begin
                  // far below the subnormal range: only sticky survives
                  rm_ff <= {107'h0, 1'b1};
                  re_ff <= 14'sd1;
               end else if (rm_ff[107]) begin
                  rm_ff <= {1'b0, rm_ff[107:2], rm_ff[1] | rm_ff[0]};
                  re_ff <= re_ff + 14'sd1;
               end else if (re_ff < 14'sd1) begin
                  rm_ff <= {1'b0, rm_ff[107:2], rm_ff[1] | rm_ff[0]};
                  re_ff <= re_ff + 14'sd1;
               end else if (!rm_ff[106] && re_ff > 14'sd1) begin
                  rm_ff <= rm_ff << 1;
                  re_ff <= re_ff - 14'sd1;
               end else begin
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               result_ff <= r_bits;
               state_ff  <= S_DONE;
            end
            S_DONE: begin
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;
endmodule

>>> rtl/core/kter_seq.sv
// Query sequencer: loads, index check and component/mode walk over the shared unit.
module kter_seq #(
   parameter int unsigned MAX_MODES = kter_pkg::MAX_MODES_DEF,
   parameter int unsigned MAX_ROWS  = kter_pkg::MAX_ROWS_DEF,
   parameter int unsigned MAX_RANK  = kter_pkg::MAX_RANK_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kter_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kter_pkg::rsp_word_type rsp_data,
   input  logic [2:0]            mode_count,
   input  logic [6:0]            rows_mode [4],
   input  logic [4:0]            rank
);
   import kter_pkg::*;

   localparam int unsigned MW = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
   localparam int unsigned RW = $clog2(MAX_ROWS);
   localparam int unsigned KW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam int unsigned FDEPTH = (1 << MW) * (1 << RW) * (1 << KW);
   localparam int unsigned FAW = MW + RW + KW;
   localparam int unsigned WDEPTH = 1 << KW;
   localparam int unsigned NMW = $clog2(QUERY_MODES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_RD_F, S_WAIT_F, S_MUL, S_MUL_W,
      S_RD_W, S_WAIT_W, S_WMUL, S_WMUL_W, S_ADD, S_ADD_W, S_OUT
   } state_type;

   state_type     state_ff;
   req_word_type  req_ff;
   logic [63:0]   sum_ff, prod_ff;
   logic [KW:0]   comp_ff;
   logic [NMW-1:0] mode_ff;
   logic [NMW-1:0] nm_ff;
   logic [KW:0]   nr_ff;
   logic          rsp_valid_ff;
   rsp_word_type  rsp_ff;
   rsp_word_type  res_ff;
   fpu_ctl_type   fctl;
   logic [63:0]   fa, fb, fres;
   logic          fdone;
   logic [63:0]   f_rd, w_rd;
   logic          f_we, w_we;
   logic [FAW-1:0] f_waddr, f_raddr;
   logic [KW-1:0] w_waddr, w_raddr;
   logic          err;
   logic [5:0]    qidx [QUERY_MODES];
   logic [5:0]    qsel;

   always_comb begin
      qidx[0] = req_ff.query_index_0;
      qidx[1] = req_ff.query_index_1;
      qidx[2] = req_ff.query_index_2;
      qidx[3] = req_ff.query_index_3;
      qsel = qidx[mode_ff[1:0]];
      err = 1'b0;
      for (int m = 0; m < QUERY_MODES; m++) begin
         if (NMW'(m) < nm_ff &&
             ({1'b0, qidx[m]} >= ((rows_mode[m] > 7'(MAX_ROWS)) ? 7'(MAX_ROWS)
                                                                 : rows_mode[m]))) begin
            err = 1'b1;
         end
      end
   end

   wire load_hit = req_valid && req_ready;
   assign f_we = load_hit && req_data.operation == OP_LOAD_FACTOR &&
                 {30'h0, req_data.mode_select} < MAX_MODES &&
                 {26'h0, req_data.row_index} < MAX_ROWS &&
                 {28'h0, req_data.component_index} < MAX_RANK;
   assign w_we = load_hit && req_data.operation == OP_LOAD_WEIGHT &&
                 {28'h0, req_data.component_index} < MAX_RANK;
   assign f_waddr = {MW'(req_data.mode_select), RW'(req_data.row_index),
                     KW'(req_data.component_index)};
   assign w_waddr = KW'(req_data.component_index);
   assign f_raddr = {MW'(mode_ff), RW'(qsel), comp_ff[KW-1:0]};
   assign w_raddr = comp_ff[KW-1:0];

   kter_ram #(.WIDTH(64), .DEPTH(FDEPTH)) u_factor (
      .clock, .wr_en(f_we), .wr_addr(f_waddr), .wr_data(req_data.load_value),
      .rd_addr(f_raddr), .rd_data(f_rd));
   kter_ram #(.WIDTH(64), .DEPTH(WDEPTH)) u_weight (
      .clock, .wr_en(w_we), .wr_addr(w_waddr), .wr_data(req_data.load_value),
      .rd_addr(w_raddr), .rd_data(w_rd));

   always_comb begin
      fctl = '0;
      fa = prod_ff;
      fb = f_rd;
      case (state_ff)
         S_MUL:  fctl.start = 1'b1;
         S_WMUL: begin
            fctl.start = 1'b1;
            fb = w_rd;
         end
         S_ADD: begin
            fctl.start = 1'b1;
            fctl.is_add = 1'b1;
            fa = sum_ff;
            fb = prod_ff;
         end
         default: fctl = '0;
      endcase
   end

   kter_fpu u_fpu (.clock, .reset, .ctl(fctl), .op_a(fa), .op_b(fb),
                   .done(fdone), .result(fres));

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_OUT) || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            S_IDLE: begin
               if (load_hit && req_data.operation == OP_QUERY) begin
                  req_ff  <= req_data;
                  nm_ff   <= (mode_count > 3'(QUERY_MODES)) ? NMW'(QUERY_MODES)
                           : (({29'h0, mode_count} > MAX_MODES) ? NMW'(MAX_MODES)
                                                                 : NMW'(mode_count));
                  nr_ff   <= ({27'h0, rank} > MAX_RANK) ? (KW+1)'(MAX_RANK)
                                                        : (KW+1)'(rank);
                  sum_ff  <= FP_ZERO;
                  comp_ff <= '0;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (err) begin
                  res_ff   <= '{element_value: FP_ZERO, index_error: 1'b1};
                  state_ff <= S_OUT;
               end else if (comp_ff >= nr_ff) begin
                  res_ff   <= '{element_value: sum_ff, index_error: 1'b0};
                  state_ff <= S_OUT;
               end else begin
                  prod_ff  <= FP_ONE;
                  mode_ff  <= '0;
                  state_ff <= S_RD_F;
               end
            end
            S_RD_F: begin
               state_ff <= (mode_ff >= nm_ff) ? S_RD_W : S_WAIT_F;
            end
            S_WAIT_F: state_ff <= S_MUL;
            S_MUL:    state_ff <= S_MUL_W;
            S_MUL_W: begin
               if (fdone) begin
                  prod_ff  <= fres;
                  mode_ff  <= mode_ff + NMW'(1);
                  state_ff <= S_RD_F;
               end
            end
            S_RD_W:   state_ff <= S_WAIT_W;
            S_WAIT_W: state_ff <= S_WMUL;
            S_WMUL:   state_ff <= S_WMUL_W;
            S_WMUL_W: begin
               if (fdone) begin
                  prod_ff  <= fres;
                  state_ff <= S_ADD;
               end
            end
            S_ADD:    state_ff <= S_ADD_W;
            S_ADD_W: begin
               if (fdone) begin
                  sum_ff   <= fres;
                  comp_ff  <= comp_ff + (KW+1)'(1);
                  state_ff <= S_CHECK;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff   <= res_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

>>> rtl/core/kruskal_tensor_element_reconstruct.sv
// Top level of the Kruskal tensor element reconstruct block.
// Holds CP factor matrices and weights in binary64 and answers one element per query
// word. Load words are written as they are taken. A query walks rank x (modes + 1)
// multiplies and rank adds through one shared multi-cycle floating-point unit, whose
// normalization shifts one place per step, so deep cancellation and results below the
// normal range take longest. An index error is answered from the index check, before
// any floating-point work. The finished element waits in the output register, so new
// words are taken while it waits; the next query stalls only at its own end.
// Stores hold no reset value: read only entries that were loaded.
module kruskal_tensor_element_reconstruct #(
   parameter int unsigned MAX_MODES = kter_pkg::MAX_MODES_DEF,
   parameter int unsigned MAX_ROWS  = kter_pkg::MAX_ROWS_DEF,
   parameter int unsigned MAX_RANK  = kter_pkg::MAX_RANK_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  kter_pkg::req_word_type       req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output kter_pkg::rsp_word_type       rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [kter_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kter_pkg::CSR_DATA_W-1:0] csr_data
);
   import kter_pkg::*;

   logic [2:0] mode_count_ff;
   logic [6:0] rows_ff [4];
   logic [4:0] rank_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_count_ff <= 3'd3;
         for (int i = 0; i < 4; i++) rows_ff[i] <= 7'd64;
         rank_ff <= 5'd16;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_MODE_COUNT: mode_count_ff <= csr_data[2:0];
            CSR_ROWS_MODE0: rows_ff[0] <= csr_data;
            CSR_ROWS_MODE1: rows_ff[1] <= csr_data;
            CSR_ROWS_MODE2: rows_ff[2] <= csr_data;
            CSR_ROWS_MODE3: rows_ff[3] <= csr_data;
            CSR_RANK:       rank_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   kter_seq #(.MAX_MODES(MAX_MODES), .MAX_ROWS(MAX_ROWS), .MAX_RANK(MAX_RANK)) u_seq (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .mode_count(mode_count_ff), .rows_mode(rows_ff), .rank(rank_ff));
endmodule
